### design/ryc_pkg.sv
// Shared constants, types and helpers for the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps

package ryc_pkg;

   localparam int ColorW      = 8;
   localparam int FrameW      = 12;
   localparam int LStrideW    = 12;
   localparam int CStrideW    = 11;
   localparam int CsrDataW    = 12;
   localparam int CsrIndexW   = 2;
   localparam int LumaAddrW   = 22;
   localparam int ChromaAddrW = 20;
   localparam int SumW        = 16;

   localparam int DefMaxWidth  = 2048;
   localparam int DefMaxHeight = 2048;

   localparam int MidDepth = 4;
   localparam int OutDepth = 4;

   localparam logic [FrameW-1:0]   RstFrameWidth   = FrameW'(640);
   localparam logic [FrameW-1:0]   RstFrameHeight  = FrameW'(480);
   localparam logic [LStrideW-1:0] RstLumaStride   = LStrideW'(640);
   localparam logic [CStrideW-1:0] RstChromaStride = CStrideW'(320);

   // BT.601 limited-range weights
   localparam logic [SumW-1:0] KyR  = SumW'(66);
   localparam logic [SumW-1:0] KyG  = SumW'(129);
   localparam logic [SumW-1:0] KyB  = SumW'(25);
   localparam logic [SumW-1:0] KcbR = SumW'(38);
   localparam logic [SumW-1:0] KcbG = SumW'(74);
   localparam logic [SumW-1:0] KcbB = SumW'(112);
   localparam logic [SumW-1:0] KcrR = SumW'(112);
   localparam logic [SumW-1:0] KcrG = SumW'(94);
   localparam logic [SumW-1:0] KcrB = SumW'(18);
   localparam logic [SumW-1:0] RoundBias  = SumW'(128);
   localparam logic [SumW-1:0] ChromaBias = SumW'(128 + 32768);

   localparam logic [ColorW-1:0] LumaOffset = ColorW'(16);
   localparam logic [ColorW-1:0] ClampLo    = ColorW'(16);
   localparam logic [ColorW-1:0] LumaHi     = ColorW'(235);
   localparam logic [ColorW-1:0] ChromaHi   = ColorW'(240);

   typedef enum logic [CsrIndexW-1:0] {
      CsrFrameWidth   = 2'd0,
      CsrFrameHeight  = 2'd1,
      CsrLumaStride   = 2'd2,
      CsrChromaStride = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LStrideW-1:0] luma_stride;
      logic [CStrideW-1:0] chroma_stride;
   } stride_type;

   typedef struct packed {
      logic [ColorW-1:0]      luma;
      logic [LumaAddrW-1:0]   luma_address;
      logic                   chroma_valid;
      logic [ColorW-1:0]      blue_difference;
      logic [ColorW-1:0]      red_difference;
      logic [ChromaAddrW-1:0] chroma_address;
      logic                   frame_end;
   } rsp_type;

   function automatic logic [ColorW-1:0] clamp8(logic [ColorW-1:0] v,
                                                logic [ColorW-1:0] lo,
                                                logic [ColorW-1:0] hi);
      logic [ColorW-1:0] r;
      begin
         if (v < lo) r = lo;
         else if (v > hi) r = hi;
         else r = v;
         return r;
      end
   endfunction

endpackage

### design/ryc_fifo.sv
// Small first-word-fall-through queue used between and after the pipeline parts.
`timescale 1ns / 1ps

module ryc_fifo #(
   parameter int  Depth = ryc_pkg::MidDepth,
   parameter type word_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type din,
   output logic     full,
   input  logic     pop,
   output word_type dout,
   output logic     empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   word_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= din;
   end

endmodule

### design/ryc_front.sv
// Front end: accepts pixels, tracks raster position and tags chroma sites and frame end.
`timescale 1ns / 1ps

module ryc_front #(
   parameter int MAX_WIDTH  = ryc_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = ryc_pkg::DefMaxHeight
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [ryc_pkg::ColorW-1:0]    red,
   input  logic [ryc_pkg::ColorW-1:0]    green,
   input  logic [ryc_pkg::ColorW-1:0]    blue,
   input  logic [ryc_pkg::FrameW-1:0]    frame_width,
   input  logic [ryc_pkg::FrameW-1:0]    frame_height,
   input  logic                          mid_full,
   output logic                          mid_push,
   output logic [3*ryc_pkg::ColorW + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 1:0] mid_word
);

   localparam int ColW  = $clog2(MAX_WIDTH);
   localparam int RowW  = $clog2(MAX_HEIGHT);
   localparam int WCmpW = (ColW + 1 > ryc_pkg::FrameW) ? ColW + 1 : ryc_pkg::FrameW;
   localparam int HCmpW = (RowW + 1 > ryc_pkg::FrameW) ? RowW + 1 : ryc_pkg::FrameW;

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [WCmpW-1:0] width_eff;
   logic [HCmpW-1:0] height_eff;
   logic             accept, last_col, last_row, chroma_site, frame_end;

   // zero acts as one, anything past the build limit acts as the limit
   always_comb begin
      if (frame_width == '0) width_eff = WCmpW'(1);
      else if (WCmpW'(frame_width) > WCmpW'(MAX_WIDTH)) width_eff = WCmpW'(MAX_WIDTH);
      else width_eff = WCmpW'(frame_width);
      if (frame_height == '0) height_eff = HCmpW'(1);
      else if (HCmpW'(frame_height) > HCmpW'(MAX_HEIGHT)) height_eff = HCmpW'(MAX_HEIGHT);
      else height_eff = HCmpW'(frame_height);
   end

   assign accept      = push && !mid_full;
   assign full        = mid_full;
   assign last_col    = (WCmpW'(col_ff) + 1'b1) >= width_eff;
   assign last_row    = (HCmpW'(row_ff) + 1'b1) >= height_eff;
   assign chroma_site = !row_ff[0] && !col_ff[0];
   assign frame_end   = last_col && last_row;
   assign mid_push    = accept;
   assign mid_word    = {red, green, blue, row_ff, col_ff, chroma_site, frame_end};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### design/ryc_back.sv
// Back end: color matrix, clamping and plane address generation, with the sums and address products registered.
`timescale 1ns / 1ps

module ryc_back #(
   parameter int MAX_WIDTH  = ryc_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = ryc_pkg::DefMaxHeight
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                mid_empty,
   input  logic [3*ryc_pkg::ColorW + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 1:0] mid_word,
   output logic                mid_pop,
   input  ryc_pkg::stride_type strides,
   input  logic                rsp_done,
   output logic                out_push,
   output ryc_pkg::rsp_type    out_word
);

   localparam int ColW    = $clog2(MAX_WIDTH);
   localparam int RowW    = $clog2(MAX_HEIGHT);
   localparam int SumW    = ryc_pkg::SumW;
   localparam int CW      = ryc_pkg::ColorW;
   localparam int LProdW  = RowW + ryc_pkg::LStrideW;
   localparam int CProdW  = RowW + ryc_pkg::CStrideW;
   localparam int LSumW   = ((LProdW > ryc_pkg::LumaAddrW) ? LProdW : ryc_pkg::LumaAddrW) + 1;
   localparam int CSumW   = ((CProdW > ryc_pkg::ChromaAddrW) ? CProdW : ryc_pkg::ChromaAddrW) + 1;
   localparam int CreditW = $clog2(ryc_pkg::OutDepth + 1);

   logic [CW-1:0]   red, green, blue;
   logic [RowW-1:0] row;
   logic [ColW-1:0] col;
   logic            chroma_site, frame_end;

   logic [SumW-1:0]    y_sum_in, cb_sum_in, cr_sum_in;
   logic [SumW-1:0]    y_sum_ff, cb_sum_ff, cr_sum_ff;
   logic [LProdW-1:0]  lprod_ff;
   logic [CProdW-1:0]  cprod_ff;
   logic [ColW-1:0]    col_ff;
   logic               chroma_site_ff, frame_end_ff;
   logic               s1_valid_ff;
   logic [CreditW-1:0] credit_ff, credit_in;

   logic [CW-1:0]    y_raw;
   logic [LSumW-1:0] laddr;
   logic [CSumW-1:0] caddr;

   assign {red, green, blue, row, col, chroma_site, frame_end} = mid_word;

   // credit covers the stage register plus the output queue, so it never overflows
   assign mid_pop = !mid_empty && (credit_ff < CreditW'(ryc_pkg::OutDepth));

   always_comb begin
      credit_in = credit_ff;
      if (mid_pop && !rsp_done) credit_in = credit_ff + 1'b1;
      else if (rsp_done && !mid_pop) credit_in = credit_ff - 1'b1;
   end

   // chroma sums carry a 128<<8 offset, so they stay positive and fit 16 bits
   always_comb begin
      y_sum_in  = ryc_pkg::KyR * SumW'(red) + ryc_pkg::KyG * SumW'(green)
                + ryc_pkg::KyB * SumW'(blue) + ryc_pkg::RoundBias;
      cb_sum_in = ryc_pkg::KcbB * SumW'(blue) + ryc_pkg::ChromaBias
                - ryc_pkg::KcbR * SumW'(red) - ryc_pkg::KcbG * SumW'(green);
      cr_sum_in = ryc_pkg::KcrR * SumW'(red) + ryc_pkg::ChromaBias
                - ryc_pkg::KcrG * SumW'(green) - ryc_pkg::KcrB * SumW'(blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         credit_ff   <= '0;
      end else begin
         s1_valid_ff <= mid_pop;
         credit_ff   <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         y_sum_ff       <= y_sum_in;
         cb_sum_ff      <= cb_sum_in;
         cr_sum_ff      <= cr_sum_in;
         lprod_ff       <= LProdW'(row) * LProdW'(strides.luma_stride);
         cprod_ff       <= CProdW'(row >> 1) * CProdW'(strides.chroma_stride);
         col_ff         <= col;
         chroma_site_ff <= chroma_site;
         frame_end_ff   <= frame_end;
      end
   end

   assign y_raw = y_sum_ff[SumW-1:SumW-CW] + ryc_pkg::LumaOffset;
   assign laddr = LSumW'(lprod_ff) + LSumW'(col_ff);
   assign caddr = CSumW'(cprod_ff) + CSumW'(col_ff >> 1);

   always_comb begin
      out_word.luma         = ryc_pkg::clamp8(y_raw, ryc_pkg::ClampLo, ryc_pkg::LumaHi);
      out_word.luma_address = laddr[ryc_pkg::LumaAddrW-1:0];
      out_word.chroma_valid = chroma_site_ff;
      out_word.frame_end    = frame_end_ff;
      if (chroma_site_ff) begin
         out_word.blue_difference = ryc_pkg::clamp8(cb_sum_ff[SumW-1:SumW-CW],
                                                    ryc_pkg::ClampLo, ryc_pkg::ChromaHi);
         out_word.red_difference  = ryc_pkg::clamp8(cr_sum_ff[SumW-1:SumW-CW],
                                                    ryc_pkg::ClampLo, ryc_pkg::ChromaHi);
         out_word.chroma_address  = caddr[ryc_pkg::ChromaAddrW-1:0];
      end else begin
         out_word.blue_difference = '0;
         out_word.red_difference  = '0;
         out_word.chroma_address  = '0;
      end
   end

   assign out_push = s1_valid_ff;

endmodule

### design/rgb_to_ycbcr420_converter_top.sv
// BT.601 RGB to YCbCr 4:2:0 converter: pixels in, luma/chroma words with plane addresses out.
// Takes one raster-order RGB pixel per clock and returns one word per pixel: clamped luma and
// its address, plus Cb/Cr and chroma address on even-row/even-column pixels (zero elsewhere)
// and a frame-end flag on the last pixel. Sustained rate is one pixel per clock in both
// directions while pop is held high. A four-word queue sits between the position tracking
// front end and the arithmetic back end, and a four-word queue holds finished words, so full
// rises only after both fill while pop is held low. Geometry and strides are written through
// the csr port; the user must do so only while the block is idle; the block does not check it.
`timescale 1ns / 1ps

module rgb_to_ycbcr420_converter_top #(
   parameter int MAX_WIDTH  = ryc_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = ryc_pkg::DefMaxHeight
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [ryc_pkg::ColorW-1:0]         req_red,
   input  logic [ryc_pkg::ColorW-1:0]         req_green,
   input  logic [ryc_pkg::ColorW-1:0]         req_blue,
   output logic                               empty,
   input  logic                               pop,
   output logic [ryc_pkg::ColorW-1:0]         rsp_luma,
   output logic [ryc_pkg::LumaAddrW-1:0]      rsp_luma_address,
   output logic                               rsp_chroma_valid,
   output logic [ryc_pkg::ColorW-1:0]         rsp_blue_difference,
   output logic [ryc_pkg::ColorW-1:0]         rsp_red_difference,
   output logic [ryc_pkg::ChromaAddrW-1:0]    rsp_chroma_address,
   output logic                               rsp_frame_end,
   input  logic                               csr_write_enable,
   input  logic [ryc_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [ryc_pkg::CsrDataW-1:0]       csr_write_data
);

   localparam int ItemW = 3 * ryc_pkg::ColorW + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 2;

   logic [ryc_pkg::FrameW-1:0]   frame_width_ff, frame_height_ff;
   logic [ryc_pkg::LStrideW-1:0] luma_stride_ff;
   logic [ryc_pkg::CStrideW-1:0] chroma_stride_ff;
   ryc_pkg::stride_type          strides;

   logic             mid_push, mid_full, mid_pop, mid_empty;
   logic [ItemW-1:0] mid_in_word, mid_out_word;
   logic             out_push;
   ryc_pkg::rsp_type out_in_word, out_word;
   logic             rsp_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= ryc_pkg::RstFrameWidth;
         frame_height_ff  <= ryc_pkg::RstFrameHeight;
         luma_stride_ff   <= ryc_pkg::RstLumaStride;
         chroma_stride_ff <= ryc_pkg::RstChromaStride;
      end else if (csr_write_enable) begin
         unique case (ryc_pkg::csr_index_type'(csr_index))
            ryc_pkg::CsrFrameWidth:   frame_width_ff   <= csr_write_data;
            ryc_pkg::CsrFrameHeight:  frame_height_ff  <= csr_write_data;
            ryc_pkg::CsrLumaStride:   luma_stride_ff   <= csr_write_data;
            ryc_pkg::CsrChromaStride: chroma_stride_ff <= csr_write_data[ryc_pkg::CStrideW-1:0];
            default: ;
         endcase
      end
   end

   assign strides.luma_stride   = luma_stride_ff;
   assign strides.chroma_stride = chroma_stride_ff;

   ryc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .mid_full     (mid_full),
      .mid_push     (mid_push),
      .mid_word     (mid_in_word)
   );

   ryc_fifo #(
      .Depth     (ryc_pkg::MidDepth),
      .word_type (logic [ItemW-1:0])
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (mid_in_word),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_out_word),
      .empty (mid_empty)
   );

   ryc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_word  (mid_out_word),
      .mid_pop   (mid_pop),
      .strides   (strides),
      .rsp_done  (rsp_done),
      .out_push  (out_push),
      .out_word  (out_in_word)
   );

   // the back end's credit keeps this queue from ever being pushed while full
   ryc_fifo #(
      .Depth     (ryc_pkg::OutDepth),
      .word_type (ryc_pkg::rsp_type)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_in_word),
      .full  (),
      .pop   (pop),
      .dout  (out_word),
      .empty (empty)
   );

   assign rsp_done = pop && !empty;

   assign rsp_luma            = out_word.luma;
   assign rsp_luma_address    = out_word.luma_address;
   assign rsp_chroma_valid    = out_word.chroma_valid;
   assign rsp_blue_difference = out_word.blue_difference;
   assign rsp_red_difference  = out_word.red_difference;
   assign rsp_chroma_address  = out_word.chroma_address;
   assign rsp_frame_end       = out_word.frame_end;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the BT.601 RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps

module tb_top;

   localparam int StallLimit = 2000;

   typedef struct packed {
      logic [ryc_pkg::ColorW-1:0] red;
      logic [ryc_pkg::ColorW-1:0] green;
      logic [ryc_pkg::ColorW-1:0] blue;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [ryc_pkg::ColorW-1:0] req_red = '0;
   logic [ryc_pkg::ColorW-1:0] req_green = '0;
   logic [ryc_pkg::ColorW-1:0] req_blue = '0;
   logic empty;
   logic pop = 1'b0;
   logic [ryc_pkg::ColorW-1:0] rsp_luma;
   logic [ryc_pkg::LumaAddrW-1:0] rsp_luma_address;
   logic rsp_chroma_valid;
   logic [ryc_pkg::ColorW-1:0] rsp_blue_difference;
   logic [ryc_pkg::ColorW-1:0] rsp_red_difference;
   logic [ryc_pkg::ChromaAddrW-1:0] rsp_chroma_address;
   logic rsp_frame_end;
   logic csr_write_enable = 1'b0;
   logic [ryc_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [ryc_pkg::CsrDataW-1:0] csr_write_data = '0;

   // shadow of the geometry registers and raster position
   logic [ryc_pkg::FrameW-1:0] cfg_frame_width = ryc_pkg::RstFrameWidth;
   logic [ryc_pkg::FrameW-1:0] cfg_frame_height = ryc_pkg::RstFrameHeight;
   logic [ryc_pkg::LStrideW-1:0] cfg_luma_stride = ryc_pkg::RstLumaStride;
   logic [ryc_pkg::CStrideW-1:0] cfg_chroma_stride = ryc_pkg::RstChromaStride;
   int unsigned pix_col = 0;
   int unsigned pix_row = 0;

   ryc_pkg::rsp_type due_words[$];
   int mismatch_count = 0;
   int idle_level = 0;
   int stall_cycles = 0;
   int random_pixels = 0;

   rgb_to_ycbcr420_converter_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_red             (req_red),
      .req_green           (req_green),
      .req_blue            (req_blue),
      .empty               (empty),
      .pop                 (pop),
      .rsp_luma            (rsp_luma),
      .rsp_luma_address    (rsp_luma_address),
      .rsp_chroma_valid    (rsp_chroma_valid),
      .rsp_blue_difference (rsp_blue_difference),
      .rsp_red_difference  (rsp_red_difference),
      .rsp_chroma_address  (rsp_chroma_address),
      .rsp_frame_end       (rsp_frame_end),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_size(logic [ryc_pkg::FrameW-1:0] v,
                                                  int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic int clamp_level(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // computes the word for one pixel and advances the raster position
   function automatic ryc_pkg::rsp_type convert_pixel(pixel_type px);
      ryc_pkg::rsp_type word;
      int ri, gi, bi;
      int unsigned eff_w, eff_h;
      logic last_c, last_r;
      longint unsigned laddr, caddr;
      ri = px.red;
      gi = px.green;
      bi = px.blue;
      eff_w = effective_size(cfg_frame_width, ryc_pkg::DefMaxWidth);
      eff_h = effective_size(cfg_frame_height, ryc_pkg::DefMaxHeight);
      last_c = (pix_col + 1) >= eff_w;
      last_r = (pix_row + 1) >= eff_h;
      word = '0;
      word.luma = ryc_pkg::ColorW'(clamp_level(((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16,
                                               16, 235));
      laddr = longint'(pix_row) * cfg_luma_stride + pix_col;
      word.luma_address = ryc_pkg::LumaAddrW'(laddr);
      word.chroma_valid = (pix_row[0] == 1'b0) && (pix_col[0] == 1'b0);
      if (word.chroma_valid) begin
         word.blue_difference = ryc_pkg::ColorW'(clamp_level(
            (-38 * ri - 74 * gi + 112 * bi + 128 + 32768) >>> 8, 16, 240));
         word.red_difference = ryc_pkg::ColorW'(clamp_level(
            (112 * ri - 94 * gi - 18 * bi + 128 + 32768) >>> 8, 16, 240));
         caddr = longint'(pix_row >> 1) * cfg_chroma_stride + (pix_col >> 1);
         word.chroma_address = ryc_pkg::ChromaAddrW'(caddr);
      end
      word.frame_end = last_c && last_r;
      if (last_c) begin
         pix_col = 0;
         pix_row = last_r ? 0 : pix_row + 1;
      end else begin
         pix_col = pix_col + 1;
      end
      return word;
   endfunction

   function automatic logic [ryc_pkg::ColorW-1:0] random_color();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return ryc_pkg::ColorW'($urandom());
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red = random_color();
      px.green = random_color();
      px.blue = random_color();
      return px;
   endfunction

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = (idle_level > 0 && $urandom_range(0, 7) < idle_level) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      do @(posedge clock); while (full);
      due_words.push_back(convert_pixel(px));
   endtask

   task automatic send_random(int count);
      repeat (count) begin
         send_pixel(random_pixel());
      end
   endtask

   // no words in flight before the registers change
   task automatic wait_idle();
      @(negedge clock);
      push <= 1'b0;
      while (due_words.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(ryc_pkg::csr_index_type idx,
                            logic [ryc_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         ryc_pkg::CsrFrameWidth:   cfg_frame_width = value;
         ryc_pkg::CsrFrameHeight:  cfg_frame_height = value;
         ryc_pkg::CsrLumaStride:   cfg_luma_stride = value;
         ryc_pkg::CsrChromaStride: cfg_chroma_stride = value[ryc_pkg::CStrideW-1:0];
         default: ;
      endcase
   endtask

   function automatic void pick_idle();
      idle_level = $urandom_range(0, 3);
   endfunction

   // default geometry first, then narrow the frame while mid-row
   task automatic test_reset_geometry();
      pixel_type colors[12];
      colors = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
                 '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'h00, 8'hFF, 8'hFF},
                 '{8'hFF, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00}, '{8'h55, 8'hAA, 8'h55},
                 '{8'hAA, 8'h55, 8'hAA}, '{8'h80, 8'h80, 8'h80}, '{8'h01, 8'hFE, 8'h7F}};
      idle_level = 0;
      for (int i = 0; i < 4; i++) send_pixel(colors[i]);
      wait_idle();
      write_reg(ryc_pkg::CsrFrameWidth, 12'd2);
      for (int i = 4; i < 12; i++) send_pixel(colors[i]);
      wait_idle();
   endtask

   // zero sizes act as one, zero strides collapse rows
   task automatic test_degenerate_geometry();
      write_reg(ryc_pkg::CsrFrameWidth, 12'd0);
      write_reg(ryc_pkg::CsrFrameHeight, 12'd0);
      write_reg(ryc_pkg::CsrLumaStride, 12'd0);
      write_reg(ryc_pkg::CsrChromaStride, 12'd0);
      send_random(3);
      wait_idle();
      write_reg(ryc_pkg::CsrFrameWidth, 12'd3);
      send_random(4);
      wait_idle();
   endtask

   task automatic test_mid_frame_resize();
      pick_idle();
      write_reg(ryc_pkg::CsrFrameWidth, 12'd8);
      write_reg(ryc_pkg::CsrFrameHeight, 12'd8);
      write_reg(ryc_pkg::CsrLumaStride, 12'd16);
      write_reg(ryc_pkg::CsrChromaStride, 12'd8);
      send_random(8 * 8 - 1 - (pix_row * 8 + pix_col) % 64 + 13);
      wait_idle();
      write_reg(ryc_pkg::CsrFrameWidth, 12'd3);
      write_reg(ryc_pkg::CsrFrameHeight, 12'd1);
      send_random(6);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int unsigned w_val, h_val, eff_w, eff_h, count;
      while (random_pixels < 1000) begin
         case ($urandom_range(0, 9))
            0: w_val = 0;
            1: w_val = $urandom_range(ryc_pkg::DefMaxWidth + 1, 4095);
            2: w_val = $urandom_range(13, 64);
            default: w_val = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h_val = 0;
            1: h_val = $urandom_range(ryc_pkg::DefMaxHeight + 1, 4095);
            default: h_val = $urandom_range(1, 6);
         endcase
         if ($urandom_range(0, 3) != 0)
            write_reg(ryc_pkg::CsrFrameWidth, ryc_pkg::CsrDataW'(w_val));
         if ($urandom_range(0, 3) != 0)
            write_reg(ryc_pkg::CsrFrameHeight, ryc_pkg::CsrDataW'(h_val));
         if ($urandom_range(0, 2) != 0)
            write_reg(ryc_pkg::CsrLumaStride, ryc_pkg::CsrDataW'($urandom()));
         if ($urandom_range(0, 2) != 0)
            write_reg(ryc_pkg::CsrChromaStride, ryc_pkg::CsrDataW'($urandom()));
         eff_w = effective_size(cfg_frame_width, ryc_pkg::DefMaxWidth);
         eff_h = effective_size(cfg_frame_height, ryc_pkg::DefMaxHeight);
         // mostly whole frames from the current position, sometimes a ragged cut
         if (eff_w * eff_h <= 150 && $urandom_range(0, 3) != 0)
            count = eff_w * eff_h - ((pix_row * eff_w + pix_col) % (eff_w * eff_h))
                    + eff_w * eff_h * $urandom_range(0, 1);
         else
            count = $urandom_range(1, 60);
         if (count > 200) count = 200;
         pick_idle();
         send_random(count);
         random_pixels += count;
         wait_idle();
      end
   endtask

   task automatic test_full_rate();
      idle_level = 0;
      write_reg(ryc_pkg::CsrFrameWidth, 12'd6);
      write_reg(ryc_pkg::CsrFrameHeight, 12'd4);
      write_reg(ryc_pkg::CsrLumaStride, 12'd16);
      write_reg(ryc_pkg::CsrChromaStride, 12'd8);
      send_random(120);
   endtask

   initial begin : result_drain
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if (idle_level > 0 && $urandom_range(0, 7) < idle_level)
               stall_left = $urandom_range(1, 17);
         end
      end
   end

   always @(posedge clock) begin
      ryc_pkg::rsp_type got, want;
      if (!reset && pop && !empty) begin
         got.luma = rsp_luma;
         got.luma_address = rsp_luma_address;
         got.chroma_valid = rsp_chroma_valid;
         got.blue_difference = rsp_blue_difference;
         got.red_difference = rsp_red_difference;
         got.chroma_address = rsp_chroma_address;
         got.frame_end = rsp_frame_end;
         if (due_words.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: Y=%0d laddr=%0h", got.luma, got.luma_address);
            mismatch_count++;
         end else begin
            want = due_words.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("word mismatch: exp Y=%0d la=%0h cv=%0b cb=%0d cr=%0d ca=%0h fe=%0b",
                           want.luma, want.luma_address, want.chroma_valid,
                           want.blue_difference, want.red_difference, want.chroma_address,
                           want.frame_end);
                  $display("               got Y=%0d la=%0h cv=%0b cb=%0d cr=%0d ca=%0h fe=%0b",
                           got.luma, got.luma_address, got.chroma_valid,
                           got.blue_difference, got.red_difference, got.chroma_address,
                           got.frame_end);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: too long without a word moving on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_degenerate_geometry();
      test_mid_frame_resize();
      test_random_frames();
      test_full_rate();
      @(negedge clock);
      push <= 1'b0;
      while (due_words.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
